/* design/guid_text_parser_assert.svh */
// Assertion macros used by the GUID text parser RTL.
`ifndef GUID_TEXT_PARSER_ASSERT_SVH
`define GUID_TEXT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, switched off during reset.
`define GTP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("guid_text_parser assertion failed");
// Next-cycle implication, switched off during reset.
`define GTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("guid_text_parser assertion failed");
`else
`define GTP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/gtp_pkg.sv */
// Types, constants and helper functions of the GUID text parser.
`default_nettype none
package gtp_pkg;

   localparam int CHAR_W       = 8;
   localparam int HALF_W       = 64;
   localparam int NIBBLE_W     = 4;
   localparam int COUNT_W      = 6;
   localparam logic [COUNT_W-1:0] DIGITS_NEEDED = 6'd32;

   // Fixed marker over bytes 4..11.
   localparam logic [31:0] MARKER_UPPER_LOW32  = 32'h0000_1000;
   localparam logic [31:0] MARKER_LOWER_HIGH32 = 32'h8000_00aa;

   localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LBRACE = 8'h7b;
   localparam logic [CHAR_W-1:0] CHAR_RBRACE = 8'h7d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_F   = 8'h46;

   typedef struct packed {
      logic                bad;
      logic [NIBBLE_W-1:0] value;
   } nibble_type;

   // Collection state handed to the result assembler.
   typedef struct packed {
      logic [COUNT_W-1:0] digit_count;
      logic               bad_digit_seen;
   } scan_state_type;

   function automatic logic is_separator(input logic [CHAR_W-1:0] ch);
      return (ch == CHAR_DASH) || (ch == CHAR_SPACE) ||
             (ch == CHAR_LBRACE) || (ch == CHAR_RBRACE);
   endfunction

   // Bad characters decode as nibble 0 with the bad flag set.
   function automatic nibble_type decode_nibble(input logic [CHAR_W-1:0] ch);
      nibble_type        res;
      logic [CHAR_W-1:0] diff;
      res  = '0;
      diff = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff      = ch - CHAR_ZERO;
         res.value = diff[NIBBLE_W-1:0];
      end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
         diff      = ch - CHAR_LC_A + 8'd10;
         res.value = diff[NIBBLE_W-1:0];
      end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
         diff      = ch - CHAR_UC_A + 8'd10;
         res.value = diff[NIBBLE_W-1:0];
      end else begin
         res.bad = 1'b1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* design/gtp_req_if.sv */
// Character channel of the GUID text parser.
`default_nettype none
interface gtp_req_if;
   logic                     valid;
   logic                     ready;
   logic [gtp_pkg::CHAR_W-1:0] character;
   logic                     text_end;

   modport source (output valid, output character, output text_end, input ready);
   modport sink   (input valid, input character, input text_end, output ready);
endinterface
`default_nettype wire

/* design/gtp_rsp_if.sv */
// Result channel of the GUID text parser.
`default_nettype none
interface gtp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gtp_pkg::HALF_W-1:0] guid_upper;
   logic [gtp_pkg::HALF_W-1:0] guid_lower;
   logic                       status;

   modport source (output valid, output guid_upper, output guid_lower, output status,
                   input ready);
   modport sink   (input valid, input guid_upper, input guid_lower, input status,
                   output ready);
endinterface
`default_nettype wire

/* design/gtp_assemble.sv */
// Result assembly: status, marker check and mixed-endian byte swap.
`default_nettype none
module gtp_assemble (
   input  wire logic [gtp_pkg::HALF_W-1:0] acc_upper,
   input  wire logic [gtp_pkg::HALF_W-1:0] acc_lower,
   input  wire gtp_pkg::scan_state_type    scan,
   output logic [gtp_pkg::HALF_W-1:0]      guid_upper,
   output logic [gtp_pkg::HALF_W-1:0]      guid_lower,
   output logic                            status
);
   import gtp_pkg::*;

   logic                marker_match;
   logic [HALF_W-1:0]   swapped_upper;

   assign marker_match = (acc_upper[31:0] == MARKER_UPPER_LOW32) &&
                         (acc_lower[63:32] == MARKER_LOWER_HIGH32);

   // Reverse bytes 0..3, swap 4 with 5 and 6 with 7.
   assign swapped_upper = {acc_upper[39:32], acc_upper[47:40], acc_upper[55:48],
                           acc_upper[63:56], acc_upper[23:16], acc_upper[31:24],
                           acc_upper[7:0],   acc_upper[15:8]};

   always_comb begin
      status     = (scan.digit_count != DIGITS_NEEDED) || scan.bad_digit_seen;
      guid_upper = '0;
      guid_lower = '0;
      if (!status) begin
         guid_upper = marker_match ? acc_upper : swapped_upper;
         guid_lower = acc_lower;
      end
   end

endmodule
`default_nettype wire

/* design/guid_text_parser.sv */
// Top level of the GUID text parser.
//
//  channel | direction | payload                               | handshake
//  --------+-----------+---------------------------------------+-------------
//  req_if  | in        | character[7:0], text_end              | valid/ready
//  rsp_if  | out       | guid_upper[63:0], guid_lower[63:0],   | valid/ready
//          |           | status                                |
//
// One character transaction is taken every cycle while req_if.ready is high;
// an end-of-text transaction loads its result into the output register.
// The collection state (count, 128-bit accumulator, bad flag) is one register
// stage; the result register sits behind the assembly logic.
// Reset is synchronous and clears the count, the bad flag, the accumulator
// and the result valid.
// req_if.ready drops only while a result is held and rsp_if.ready is low.
`default_nettype none
module guid_text_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   gtp_req_if.sink    req_if,
   gtp_rsp_if.source  rsp_if
);
   import gtp_pkg::*;
`include "guid_text_parser_assert.svh"

   // Collection state
   logic [HALF_W-1:0]  acc_upper_ff, acc_upper_in;
   logic [HALF_W-1:0]  acc_lower_ff, acc_lower_in;
   scan_state_type     scan_ff, scan_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HALF_W-1:0]  rsp_upper_ff, rsp_upper_in;
   logic [HALF_W-1:0]  rsp_lower_ff, rsp_lower_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               end_fire;
   logic               collect;
   nibble_type         nib;
   logic [HALF_W-1:0]  asm_upper;
   logic [HALF_W-1:0]  asm_lower;
   logic               asm_status;

   // Accept while the result register is empty or being emptied.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign end_fire     = req_fire && req_if.text_end;

   // Collect only non-separator characters, and only the first 32 of them.
   assign nib     = decode_nibble(req_if.character);
   assign collect = req_fire && !req_if.text_end && !is_separator(req_if.character) &&
                    (scan_ff.digit_count < DIGITS_NEEDED);

   gtp_assemble u_assemble (
      .acc_upper  (acc_upper_ff),
      .acc_lower  (acc_lower_ff),
      .scan       (scan_ff),
      .guid_upper (asm_upper),
      .guid_lower (asm_lower),
      .status     (asm_status)
   );

   always_comb begin
      acc_upper_in = acc_upper_ff;
      acc_lower_in = acc_lower_ff;
      scan_in      = scan_ff;
      if (end_fire) begin
         // Clear for the next text.
         acc_upper_in = '0;
         acc_lower_in = '0;
         scan_in      = '0;
      end else if (collect) begin
         // Shift the 128-bit value left by one nibble.
         acc_upper_in = {acc_upper_ff[HALF_W-NIBBLE_W-1:0],
                         acc_lower_ff[HALF_W-1 -: NIBBLE_W]};
         acc_lower_in = {acc_lower_ff[HALF_W-NIBBLE_W-1:0],
                         nib.bad ? {NIBBLE_W{1'b0}} : nib.value};
         scan_in.digit_count    = scan_ff.digit_count + 1'b1;
         scan_in.bad_digit_seen = scan_ff.bad_digit_seen | nib.bad;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_upper_in  = rsp_upper_ff;
      rsp_lower_in  = rsp_lower_ff;
      rsp_status_in = rsp_status_ff;
      if (end_fire) begin
         // Load a fresh result; the old one is leaving this cycle.
         rsp_valid_in  = 1'b1;
         rsp_upper_in  = asm_upper;
         rsp_lower_in  = asm_lower;
         rsp_status_in = asm_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_upper_ff <= '0;
         acc_lower_ff <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_upper_ff <= acc_upper_in;
         acc_lower_ff <= acc_lower_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_upper_ff  <= rsp_upper_in;
      rsp_lower_ff  <= rsp_lower_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.guid_upper = rsp_upper_ff;
   assign rsp_if.guid_lower = rsp_lower_ff;
   assign rsp_if.status     = rsp_status_ff;

   // Count never passes the digit limit.
   `GTP_ASSERT_IMPLY(a_count_limit, clock, reset, 1'b1, scan_ff.digit_count <= DIGITS_NEEDED)
   // An accepted end of text always leaves a result behind, with the state cleared.
   `GTP_ASSERT_NEXT(a_end_gives_result, clock, reset, end_fire, rsp_valid_ff && scan_ff.digit_count == '0)
   // Error results carry all-zero GUID bytes.
   `GTP_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_upper_ff == '0 && rsp_lower_ff == '0)
   // A collected digit advances the count by one.
   `GTP_ASSERT_NEXT(a_collect_count, clock, reset, collect, scan_ff.digit_count == $past(scan_ff.digit_count) + 1'b1)

endmodule
`default_nettype wire
